>>> rtl/core/rie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_pkg
// Shared types and constants of the integer instruction execute core.
// ----------------------------------------------------------------------------
package rie_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MULI = 4'd2,
        OP_ADDI = 4'd3,
        OP_BNE  = 4'd4,
        OP_ANDI = 4'd5,
        OP_ORI  = 4'd6,
        OP_J    = 4'd7,
        OP_SLL  = 4'd8,
        OP_SRL  = 4'd9,
        OP_LW   = 4'd10,
        OP_SW   = 4'd11
    } t_opcode;

    typedef struct packed {
        logic              reg_write;
        logic [REG_AW-1:0] dest_index;
        logic [XLEN-1:0]   write_value;
        logic              redirect;
        logic [XLEN-1:0]   redirect_pc;
        logic              store_done;
        logic [XLEN-1:0]   access_addr;
        logic              addr_fault;
        logic              bad_opcode;
    } t_result;

endpackage : rie_pkg
`default_nettype wire

>>> rtl/core/rie_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_if
// Valid/ready channels carrying instructions in and results out.
// ----------------------------------------------------------------------------
interface rie_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [31:0] next_pc;

    modport source (output valid, output instr_word, output next_pc, input ready);
    modport sink   (input valid, input instr_word, input next_pc, output ready);
endinterface : rie_in_if

interface rie_out_if;
    logic        valid;
    logic        ready;
    logic        reg_write;
    logic [4:0]  dest_index;
    logic [31:0] write_value;
    logic        redirect;
    logic [31:0] redirect_pc;
    logic        store_done;
    logic [31:0] access_addr;
    logic        addr_fault;
    logic        bad_opcode;

    modport source (output valid, output reg_write, output dest_index, output write_value,
                    output redirect, output redirect_pc, output store_done,
                    output access_addr, output addr_fault, output bad_opcode, input ready);
    modport sink   (input valid, input reg_write, input dest_index, input write_value,
                    input redirect, input redirect_pc, input store_done,
                    input access_addr, input addr_fault, input bad_opcode, output ready);
endinterface : rie_out_if
`default_nettype wire

>>> rtl/core/rie_regfile.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_regfile
// Register file with two registered read ports, one write port and
// write-through forwarding. Entries read as zero until first written.
// ----------------------------------------------------------------------------
module rie_regfile (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [rie_pkg::REG_AW-1:0] i_ra_a,
    input  wire logic [rie_pkg::REG_AW-1:0] i_ra_b,
    input  wire logic                      i_we,
    input  wire logic [rie_pkg::REG_AW-1:0] i_wa,
    input  wire logic [rie_pkg::XLEN-1:0]   i_wd,
    output logic      [rie_pkg::XLEN-1:0]   o_rd_a,
    output logic      [rie_pkg::XLEN-1:0]   o_rd_b
);
    import rie_pkg::*;

    logic [XLEN-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [XLEN-1:0]      r_rd_a;
    logic [XLEN-1:0]      r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_rd_en) begin
            if (i_ra_a == '0) begin
                r_rd_a <= '0;
            end else if (i_we && i_wa == i_ra_a) begin
                r_rd_a <= i_wd;
            end else begin
                r_rd_a <= r_vld[i_ra_a] ? r_mem[i_ra_a] : '0;
            end
            if (i_ra_b == '0) begin
                r_rd_b <= '0;
            end else if (i_we && i_wa == i_ra_b) begin
                r_rd_b <= i_wd;
            end else begin
                r_rd_b <= r_vld[i_ra_b] ? r_mem[i_ra_b] : '0;
            end
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule : rie_regfile
`default_nettype wire

>>> rtl/core/rie_dmem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_dmem
// Data memory with one registered read port and one write port. After reset
// it sweeps every word to zero, one word per cycle, and reports busy.
// ----------------------------------------------------------------------------
module rie_dmem #(
    parameter int MEM_WORDS = 2048,
    parameter int AW        = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    output logic                          o_busy,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_ra,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_wa,
    input  wire logic [rie_pkg::XLEN-1:0] i_wd,
    output logic      [rie_pkg::XLEN-1:0] o_rd
);
    import rie_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

    logic [XLEN-1:0] r_mem [MEM_WORDS];
    logic [XLEN-1:0] r_rd;
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_addr;
    logic            n_we;
    logic [AW-1:0]   n_wa;
    logic [XLEN-1:0] n_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        n_we = r_clr_busy ? 1'b1 : i_we;
        n_wa = r_clr_busy ? r_clr_addr : i_wa;
        n_wd = r_clr_busy ? '0 : i_wd;
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_busy = r_clr_busy;
    assign o_rd   = r_rd;

endmodule : rie_dmem
`default_nettype wire

>>> rtl/core/rie_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rie_alu
// Decodes one instruction and computes its result from the two operands.
// A load reports zero as its value; the loaded word is filled in later.
// ----------------------------------------------------------------------------
module rie_alu #(
    parameter int MEM_WORDS = 2048
) (
    input  wire logic [31:0]              i_instr,
    input  wire logic [31:0]              i_npc,
    input  wire logic [rie_pkg::XLEN-1:0] i_a,
    input  wire logic [rie_pkg::XLEN-1:0] i_b,
    output rie_pkg::t_result              o_res,
    output logic                          o_load
);
    import rie_pkg::*;

    t_opcode         op;
    logic [4:0]      r1;
    logic [12:0]     shamt;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] acc;
    logic            fault;
    logic            writes;
    logic [XLEN-1:0] val;
    logic [63:0]     prod;

    always_comb begin
        op     = t_opcode'(i_instr[31:28]);
        r1     = i_instr[27:23];
        shamt  = i_instr[12:0];
        imm    = {{14{i_instr[17]}}, i_instr[17:0]};
        acc    = i_a + imm;
        fault  = acc >= 32'(MEM_WORDS);
        prod   = {32'd0, i_a} * {32'd0, imm};
        writes = 1'b0;
        val    = '0;
        o_load = 1'b0;
        o_res  = '0;
        case (op)
            OP_ADD: begin
                writes = 1'b1;
                val    = i_a + i_b;
            end
            OP_SUB: begin
                writes = 1'b1;
                val    = i_a - i_b;
            end
            OP_MULI: begin
                writes = 1'b1;
                val    = prod[31:0];
            end
            OP_ADDI: begin
                writes = 1'b1;
                val    = acc;
            end
            OP_ANDI: begin
                writes = 1'b1;
                val    = i_a & imm;
            end
            OP_ORI: begin
                writes = 1'b1;
                val    = i_a | imm;
            end
            OP_SLL: begin
                writes = 1'b1;
                val    = (|shamt[12:5]) ? '0 : (i_a << shamt[4:0]);
            end
            OP_SRL: begin
                writes = 1'b1;
                val    = (|shamt[12:5]) ? '0 : (i_a >> shamt[4:0]);
            end
            OP_BNE: begin
                if (i_a != i_b) begin
                    o_res.redirect    = 1'b1;
                    o_res.redirect_pc = i_npc + imm;
                end
            end
            OP_J: begin
                o_res.redirect    = 1'b1;
                o_res.redirect_pc = {i_npc[31:28], i_instr[27:0]};
            end
            OP_LW: begin
                writes             = 1'b1;
                o_load             = !fault;
                o_res.access_addr  = acc;
                o_res.addr_fault   = fault;
            end
            OP_SW: begin
                o_res.access_addr = acc;
                o_res.addr_fault  = fault;
                o_res.store_done  = !fault;
            end
            default: begin
                o_res.bad_opcode = 1'b1;
            end
        endcase
        if (writes) begin
            o_res.dest_index  = r1;
            o_res.write_value = val;
            o_res.reg_write   = (r1 != '0) && !o_res.addr_fault;
        end
    end

endmodule : rie_alu
`default_nettype wire

>>> rtl/core/risc_instruction_execute_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// risc_instruction_execute_core
// Executes one integer instruction per transfer against a register file and
// a data memory, and returns one result per instruction in program order.
// ----------------------------------------------------------------------------
// An instruction first reads its operands into registers and is then executed;
// a new one is taken every cycle unless the input stalls. A load that hits
// memory also passes through the data memory read register and holds the input
// until its result moves to the output register. Results sit in an output
// register, and the input stalls while that register is full and not being read
// or a load is in flight. After reset the data memory is swept to zero, during
// which no instruction is taken.
module risc_instruction_execute_core #(
    parameter int MEM_WORDS = 2048
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rie_in_if.sink     i_in,
    rie_out_if.source  o_out
);
    import rie_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic            r_ex_vld;
    logic [31:0]     r_ex_instr;
    logic [31:0]     r_ex_npc;
    logic            r_ld_vld;
    t_result         r_ld_res;
    logic            r_out_vld;
    t_result         r_out;

    logic            in_go;
    logic            out_free;
    logic            ld_go;
    logic            ex_to_ld;
    logic            ex_go;
    logic            clr_busy;
    t_opcode         in_op;
    logic [REG_AW-1:0] ra_b;
    logic [XLEN-1:0] rd_a;
    logic [XLEN-1:0] rd_b;
    logic [XLEN-1:0] ld_data;
    t_result         ex_res;
    t_result         ld_res;
    logic            ex_load;
    logic            rf_we;
    logic [REG_AW-1:0] rf_wa;
    logic [XLEN-1:0] rf_wd;

    always_comb begin
        in_op    = t_opcode'(i_in.instr_word[31:28]);
        ra_b     = (in_op == OP_BNE || in_op == OP_SW) ? i_in.instr_word[27:23]
                                                       : i_in.instr_word[17:13];
        out_free = !r_out_vld || o_out.ready;
        ld_go    = r_ld_vld && out_free;
        ex_to_ld = r_ex_vld && ex_load && !r_ld_vld;
        ex_go    = r_ex_vld && !ex_load && !r_ld_vld && out_free;
        i_in.ready = !clr_busy && !r_ld_vld && (!r_ex_vld || ex_go);
        in_go    = i_in.valid && i_in.ready;
        ld_res   = r_ld_res;
        ld_res.write_value = ld_data;
        rf_we    = ld_go ? r_ld_res.reg_write : (ex_go && ex_res.reg_write);
        rf_wa    = ld_go ? r_ld_res.dest_index : ex_res.dest_index;
        rf_wd    = ld_go ? ld_data : ex_res.write_value;
    end

    rie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (in_go),
        .i_ra_a  (i_in.instr_word[22:18]),
        .i_ra_b  (ra_b),
        .i_we    (rf_we),
        .i_wa    (rf_wa),
        .i_wd    (rf_wd),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    rie_alu #(
        .MEM_WORDS (MEM_WORDS)
    ) u_alu (
        .i_instr (r_ex_instr),
        .i_npc   (r_ex_npc),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_res   (ex_res),
        .o_load  (ex_load)
    );

    rie_dmem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .i_re    (ex_to_ld),
        .i_ra    (ex_res.access_addr[AW-1:0]),
        .i_we    (ex_go && ex_res.store_done),
        .i_wa    (ex_res.access_addr[AW-1:0]),
        .i_wd    (rd_b),
        .o_rd    (ld_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_ld_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_go) begin
                r_ex_vld <= 1'b1;
            end else if (ex_go || ex_to_ld) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_to_ld) begin
                r_ld_vld <= 1'b1;
            end else if (ld_go) begin
                r_ld_vld <= 1'b0;
            end
            if (ld_go || ex_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_ex_instr <= i_in.instr_word;
            r_ex_npc   <= i_in.next_pc;
        end
        if (ex_to_ld) begin
            r_ld_res <= ex_res;
        end
        if (ld_go) begin
            r_out <= ld_res;
        end else if (ex_go) begin
            r_out <= ex_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.reg_write   = r_out.reg_write;
    assign o_out.dest_index  = r_out.dest_index;
    assign o_out.write_value = r_out.write_value;
    assign o_out.redirect    = r_out.redirect;
    assign o_out.redirect_pc = r_out.redirect_pc;
    assign o_out.store_done  = r_out.store_done;
    assign o_out.access_addr = r_out.access_addr;
    assign o_out.addr_fault  = r_out.addr_fault;
    assign o_out.bad_opcode  = r_out.bad_opcode;

endmodule : risc_instruction_execute_core
`default_nettype wire

>>> test/risc_instruction_execute_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc_instruction_execute_core_tb
// Drives instruction streams into the execute core and checks every result
// against a behavioral copy of the register file and data memory.
// ----------------------------------------------------------------------------
module risc_instruction_execute_core_tb;
    import rie_pkg::*;

    localparam int MEM_WORDS  = 2048;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    rie_in_if  in_ch();
    rie_out_if out_ch();

    risc_instruction_execute_core #(.MEM_WORDS(MEM_WORDS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    logic [31:0] regs_model [REG_COUNT];
    logic [31:0] mem_model  [MEM_WORDS];
    t_result     pending_results [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          sent_count;
    int          checked_count;
    int          idle_cycles;
    bit          timed_out;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] read_reg(input logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : regs_model[idx];
    endfunction

    function automatic t_result execute_instr(input logic [31:0] w, input logic [31:0] npc);
        t_result     r;
        logic [3:0]  op;
        logic [4:0]  r1;
        logic [31:0] a;
        logic [31:0] imm;
        logic [12:0] shamt;
        logic [31:0] val;
        bit          writes;
        r      = '0;
        op     = w[31:28];
        r1     = w[27:23];
        a      = read_reg(w[22:18]);
        imm    = {{14{w[17]}}, w[17:0]};
        shamt  = w[12:0];
        val    = '0;
        writes = 1'b0;
        case (op)
            OP_ADD:  begin val = a + read_reg(w[17:13]); writes = 1; end
            OP_SUB:  begin val = a - read_reg(w[17:13]); writes = 1; end
            OP_MULI: begin val = a * imm; writes = 1; end
            OP_ADDI: begin val = a + imm; writes = 1; end
            OP_ANDI: begin val = a & imm; writes = 1; end
            OP_ORI:  begin val = a | imm; writes = 1; end
            OP_SLL:  begin val = (shamt >= 32) ? 32'd0 : a << shamt; writes = 1; end
            OP_SRL:  begin val = (shamt >= 32) ? 32'd0 : a >> shamt; writes = 1; end
            OP_BNE: begin
                if (read_reg(r1) != a) begin
                    r.redirect    = 1'b1;
                    r.redirect_pc = npc + imm;
                end
            end
            OP_J: begin
                r.redirect    = 1'b1;
                r.redirect_pc = {npc[31:28], w[27:0]};
            end
            OP_LW: begin
                writes        = 1;
                r.access_addr = a + imm;
                if (r.access_addr >= MEM_WORDS) r.addr_fault = 1'b1;
                else val = mem_model[r.access_addr];
            end
            OP_SW: begin
                r.access_addr = a + imm;
                if (r.access_addr >= MEM_WORDS) begin
                    r.addr_fault = 1'b1;
                end else begin
                    mem_model[r.access_addr] = read_reg(r1);
                    r.store_done = 1'b1;
                end
            end
            default: r.bad_opcode = 1'b1;
        endcase
        if (writes) begin
            r.dest_index  = r1;
            r.write_value = val;
            if (!r.addr_fault && r1 != 5'd0) begin
                regs_model[r1] = val;
                r.reg_write    = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] make_instr(input logic [3:0] op, input logic [4:0] r1,
                                               input logic [4:0] r2, input logic [17:0] imm);
        return {op, r1, r2, imm};
    endfunction

    task automatic send_instr(input logic [31:0] w, input logic [31:0] npc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.instr_word <= w;
        in_ch.next_pc    <= npc;
        pending_results.push_back(execute_instr(w, npc));
        sent_count++;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.reg_write, out_ch.dest_index, out_ch.write_value, out_ch.redirect,
                    out_ch.redirect_pc, out_ch.store_done, out_ch.access_addr,
                    out_ch.addr_fault, out_ch.bad_opcode};
            checked_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WDOG_LIMIT + 2 * MEM_WORDS) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [3:0] op;
        send_instr(make_instr(OP_ADDI, 5'd1, 5'd0, 18'h1FFFF), 32'h0);
        send_instr(make_instr(OP_ADDI, 5'd2, 5'd0, 18'h20000), 32'h4);
        send_instr(make_instr(OP_ADDI, 5'd3, 5'd0, 18'h3FFFF), 32'h8);
        send_instr(make_instr(OP_ADD, 5'd4, 5'd1, {5'd2, 13'd0}), 32'hC);
        send_instr(make_instr(OP_SUB, 5'd5, 5'd2, {5'd1, 13'd0}), 32'h10);
        send_instr(make_instr(OP_MULI, 5'd6, 5'd1, 18'h3FFFF), 32'h14);
        send_instr(make_instr(OP_ANDI, 5'd7, 5'd3, 18'h2AAAA), 32'h18);
        send_instr(make_instr(OP_ORI, 5'd8, 5'd0, 18'h15555), 32'h1C);
        send_instr(make_instr(OP_SLL, 5'd9, 5'd1, 18'd31), 32'h20);
        send_instr(make_instr(OP_SLL, 5'd9, 5'd1, 18'd32), 32'h24);
        send_instr(make_instr(OP_SRL, 5'd10, 5'd3, 18'h1FFF), 32'h28);
        send_instr(make_instr(OP_SRL, 5'd10, 5'd3, 18'd1), 32'h2C);
        send_instr(make_instr(OP_ADD, 5'd0, 5'd1, {5'd1, 13'd0}), 32'h30);
        send_instr(make_instr(OP_SW, 5'd3, 5'd0, 18'd2047), 32'h34);
        send_instr(make_instr(OP_LW, 5'd11, 5'd0, 18'd2047), 32'h38);
        send_instr(make_instr(OP_LW, 5'd12, 5'd0, 18'd2048), 32'h3C);
        send_instr(make_instr(OP_SW, 5'd3, 5'd3, 18'd0), 32'h40);
        send_instr(make_instr(OP_LW, 5'd0, 5'd0, 18'd2047), 32'h44);
        send_instr(make_instr(OP_BNE, 5'd1, 5'd2, 18'h3FFF0), 32'h10);
        send_instr(make_instr(OP_BNE, 5'd1, 5'd1, 18'h10), 32'h48);
        send_instr(make_instr(OP_BNE, 5'd3, 5'd0, 18'h1FFFF), 32'hFFFF_FFF0);
        send_instr({OP_J, 28'hFFFFFFF}, 32'hA000_0000);
        for (int i = 12; i < 16; i++) begin
            op = 4'(i);
            send_instr({op, 28'hFFFFFFF}, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_random(input int count, input int sendp, input int recvp);
        logic [31:0] w;
        logic [3:0]  op;
        int          kind;
        send_idle_pct  = sendp;
        recv_stall_pct = recvp;
        for (int i = 0; i < count; i++) begin
            w    = $urandom;
            kind = $urandom_range(99);
            op   = (kind < 3) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
            w[31:28] = op;
            // Keep most memory accesses in range by basing them on R0.
            if ((op == OP_LW || op == OP_SW) && kind < 80) begin
                w[22:18] = 5'd0;
                w[17:0]  = 18'($urandom_range(MEM_WORDS - 1));
            end
            if ((op == OP_SLL || op == OP_SRL) && kind < 70) w[12:0] = 13'($urandom_range(31));
            if (op == OP_BNE && kind < 30) w[22:18] = w[27:23];
            send_instr(w, $urandom);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.instr_word = '0;
        in_ch.next_pc    = '0;
        out_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        error_count      = 0;
        sent_count       = 0;
        checked_count    = 0;
        idle_cycles      = 0;
        foreach (regs_model[i]) regs_model[i] = '0;
        foreach (mem_model[i]) mem_model[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_random(400, 0, 0);
        test_random(350, 77, 0);
        test_random(350, 0, 77);
        test_random(300, 38, 38);
        repeat (20) @(posedge i_clk);
        $display("Executed %0d instructions, checked %0d results across four handshake mixes.",
                 sent_count, checked_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
